// ===== hdl/usd_pkg.sv =====
`timescale 1ns / 1ps

package usd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CpW    = 31;
    localparam int unsigned LenW   = 3;
    localparam int unsigned SkipW  = 16;

    localparam logic [SkipW-1:0] SkipMax = {SkipW{1'b1}};

    localparam logic [LenW-1:0] ClsCont  = 3'd0;
    localparam logic [LenW-1:0] ClsAscii = 3'd1;

    function automatic logic [LenW-1:0] byte_class(input logic [ByteW-1:0] b);
        logic [LenW-1:0] cls;
        if (b < 8'h80) begin
            cls = ClsAscii;
        end else if (b < 8'hc0) begin
            cls = ClsCont;
        end else if (b < 8'he0) begin
            cls = 3'd2;
        end else if (b < 8'hf0) begin
            cls = 3'd3;
        end else if (b < 8'hf8) begin
            cls = 3'd4;
        end else if (b < 8'hfc) begin
            cls = 3'd5;
        end else if (b < 8'hfe) begin
            cls = 3'd6;
        end else begin
            cls = ClsCont;
        end
        return cls;
    endfunction

    function automatic logic [SkipW-1:0] sat_add(input logic [SkipW-1:0] a,
                                                 input logic [LenW-1:0] n);
        logic [SkipW:0] s;
        s = {1'b0, a} + {{(SkipW-LenW+1){1'b0}}, n};
        return s[SkipW] ? SkipMax : s[SkipW-1:0];
    endfunction

endpackage

// ===== hdl/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps

// The decoder takes one byte of a UTF-8 stream in each input beat, using the
// original scheme with lead bytes for sequences of one to six bytes, and gives
// one output beat for each finished character: the code point of up to 31
// bits, the sequence length and the count of illegal bytes dropped since the
// previous character, which saturates at 65535.
// Both channels use valid and ready. A byte that finishes a character appears
// on the output in the cycle after its input beat; other bytes give no beat.
// One byte is taken in every cycle unless the output stalls, set by the single
// decode step between the sequence state registers and the output register.
// A byte is taken while the output register is empty or is being emptied in
// the same cycle, so a stalled receiver holds the input only once a finished
// character is waiting.
// The synchronous active-low reset returns the decoder to idle with the
// gathered code point, the byte counts and the skip count cleared, and empties
// the output register.

module utf8_stream_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [usd_pkg::ByteW-1:0]     i_in_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [usd_pkg::CpW-1:0]       o_code_point,
    output logic [usd_pkg::LenW-1:0]      o_seq_length,
    output logic [usd_pkg::SkipW-1:0]     o_skipped_bytes
);

    logic [usd_pkg::CpW-1:0]   r_accum,  n_accum;
    logic [usd_pkg::LenW-1:0]  r_needed, n_needed;
    logic [usd_pkg::LenW-1:0]  r_taken,  n_taken;
    logic [usd_pkg::SkipW-1:0] r_skip,   n_skip;

    logic                      r_out_valid;
    logic [usd_pkg::CpW-1:0]   r_out_cp,   n_out_cp;
    logic [usd_pkg::LenW-1:0]  r_out_len,  n_out_len;
    logic [usd_pkg::SkipW-1:0] r_out_skip, n_out_skip;

    logic                      accept;
    logic                      emit;
    logic [usd_pkg::LenW-1:0]  cls;
    logic [usd_pkg::SkipW-1:0] skip_base;
    logic [usd_pkg::CpW-1:0]   cont_accum;
    logic [usd_pkg::LenW-1:0]  cont_taken;
    logic [usd_pkg::ByteW-1:0] lead_bits;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        cls        = usd_pkg::byte_class(i_in_byte);
        cont_accum = {r_accum[usd_pkg::CpW-7:0], i_in_byte[5:0]};
        cont_taken = r_taken + 3'd1;
        lead_bits  = i_in_byte & (8'hff >> cls);
        skip_base  = (r_needed != 3'd0) ? usd_pkg::sat_add(r_skip, r_taken) : r_skip;

        n_accum    = r_accum;
        n_needed   = r_needed;
        n_taken    = r_taken;
        n_skip     = r_skip;
        emit       = 1'b0;
        n_out_cp   = r_out_cp;
        n_out_len  = r_out_len;
        n_out_skip = r_out_skip;

        if (r_needed != 3'd0 && cls == usd_pkg::ClsCont) begin
            if (cont_taken >= r_needed) begin
                emit       = 1'b1;
                n_out_cp   = cont_accum;
                n_out_len  = r_needed;
                n_out_skip = r_skip;
                n_accum    = '0;
                n_needed   = 3'd0;
                n_taken    = 3'd0;
                n_skip     = '0;
            end else begin
                n_accum = cont_accum;
                n_taken = cont_taken;
            end
        end else if (cls == usd_pkg::ClsCont) begin
            n_skip = usd_pkg::sat_add(r_skip, 3'd1);
        end else if (cls == usd_pkg::ClsAscii) begin
            emit       = 1'b1;
            n_out_cp   = {24'd0, i_in_byte[6:0]};
            n_out_len  = 3'd1;
            n_out_skip = skip_base;
            n_accum    = '0;
            n_needed   = 3'd0;
            n_taken    = 3'd0;
            n_skip     = '0;
        end else begin
            n_accum  = {23'd0, lead_bits};
            n_needed = cls;
            n_taken  = 3'd1;
            n_skip   = skip_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_needed    <= 3'd0;
            r_taken     <= 3'd0;
            r_skip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_accum  <= n_accum;
                r_needed <= n_needed;
                r_taken  <= n_taken;
                r_skip   <= n_skip;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_cp   <= n_out_cp;
            r_out_len  <= n_out_len;
            r_out_skip <= n_out_skip;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_code_point    = r_out_cp;
    assign o_seq_length    = r_out_len;
    assign o_skipped_bytes = r_out_skip;

`ifndef NO_ASSERTIONS
    a_idle_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_needed == 3'd0) |-> (r_taken == 3'd0))
        else $error("Byte count is nonzero while idle.");

    a_taken_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_needed != 3'd0) |-> (r_taken >= 3'd1 && r_taken < r_needed && r_needed >= 3'd2))
        else $error("Byte count outside the sequence in progress.");

    a_out_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_seq_length >= 3'd1 && o_seq_length <= 3'd6))
        else $error("Output sequence length out of range.");

    a_ascii_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seq_length == 3'd1) |-> (o_code_point < 31'd128))
        else $error("Single-byte character above the ASCII range.");

    a_skip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit) |=> (r_skip == '0 && r_needed == 3'd0))
        else $error("State not cleared after a finished character.");
`endif

endmodule

// ===== test/utf8_stream_decoder_check.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_check
    import usd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [ByteW-1:0] i_in_byte,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [CpW-1:0]   i_code_point,
    input  logic [LenW-1:0]  i_seq_length,
    input  logic [SkipW-1:0] i_skipped_bytes,
    input  logic             i_end,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_chars
);

    localparam int MaxLines = 20;

    typedef struct packed {
        logic [CpW-1:0]   cp;
        logic [LenW-1:0]  len;
        logic [SkipW-1:0] skip;
    } t_char;

    t_char            chars_due[$];
    logic [CpW-1:0]   gathered;
    logic [LenW-1:0]  seq_need;
    logic [LenW-1:0]  seq_taken;
    logic [SkipW-1:0] dropped;
    int               fails;
    int               chars_seen;
    bit               end_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_chars      = 0;
        fails        = 0;
        chars_seen   = 0;
        end_seen     = 1'b0;
    end

    function automatic logic [LenW-1:0] seq_len_of(input logic [ByteW-1:0] b);
        casez (b)
            8'b0???????: return ClsAscii;
            8'b10??????: return ClsCont;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            8'b11110???: return 3'd4;
            8'b111110??: return 3'd5;
            8'b1111110?: return 3'd6;
            default:     return ClsCont;
        endcase
    endfunction

    function automatic logic [SkipW-1:0] dropped_plus(input logic [SkipW-1:0] a,
                                                      input logic [LenW-1:0] n);
        logic [SkipW:0] s;
        s = {1'b0, a} + {{(SkipW-LenW+1){1'b0}}, n};
        return s[SkipW] ? SkipMax : s[SkipW-1:0];
    endfunction

    task automatic report(input string msg);
        fails++;
        if (fails <= MaxLines) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic finish_char(input logic [CpW-1:0] cp, input logic [LenW-1:0] len);
        t_char c;
        c.cp  = cp;
        c.len = len;
        c.skip = dropped;
        chars_due.push_back(c);
        dropped   = '0;
        gathered  = '0;
        seq_need  = '0;
        seq_taken = '0;
    endtask

    task automatic decode_byte(input logic [ByteW-1:0] b);
        logic [LenW-1:0] cls;
        bit              fresh;
        cls   = seq_len_of(b);
        fresh = 1'b1;
        if (seq_need != 0) begin
            if (cls == ClsCont) begin
                fresh     = 1'b0;
                gathered  = {gathered[CpW-7:0], b[5:0]};
                seq_taken = seq_taken + 3'd1;
                if (seq_taken >= seq_need) begin
                    finish_char(gathered, seq_need);
                end
            end else begin
                // A new start cuts the partial sequence short; its bytes are dropped.
                dropped   = dropped_plus(dropped, seq_taken);
                gathered  = '0;
                seq_need  = '0;
                seq_taken = '0;
            end
        end
        if (fresh) begin
            if (cls == ClsCont) begin
                dropped = dropped_plus(dropped, 3'd1);
            end else if (cls == ClsAscii) begin
                finish_char({24'd0, b[6:0]}, 3'd1);
            end else begin
                gathered  = {23'd0, b & (8'hff >> cls)};
                seq_need  = cls;
                seq_taken = 3'd1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_char want;
        if (!i_rst_n) begin
            chars_due.delete();
            gathered  = '0;
            seq_need  = '0;
            seq_taken = '0;
            dropped   = '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                chars_seen++;
                if (chars_due.size() == 0) begin
                    report($sformatf("output beat with no character due: cp %0h len %0d skip %0d",
                                     i_code_point, i_seq_length, i_skipped_bytes));
                end else begin
                    want = chars_due.pop_front();
                    if (i_code_point !== want.cp) begin
                        report($sformatf("code point %0h, expected %0h",
                                         i_code_point, want.cp));
                    end
                    if (i_seq_length !== want.len) begin
                        report($sformatf("sequence length %0d, expected %0d",
                                         i_seq_length, want.len));
                    end
                    if (i_skipped_bytes !== want.skip) begin
                        report($sformatf("skipped bytes %0d, expected %0d",
                                         i_skipped_bytes, want.skip));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_byte);
            end
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                if (chars_due.size() != 0) begin
                    report($sformatf("%0d characters never came out", chars_due.size()));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= chars_due.size();
        o_chars      <= chars_seen;
    end

endmodule

// ===== test/utf8_stream_decoder_test.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_test;

    import usd_pkg::*;

    localparam int unsigned RandomItems = 1000;
    localparam int unsigned HoldCycles  = 400;
    localparam int unsigned StrayRun    = 20;
    localparam int unsigned TailCycles  = 10;

    logic             i_clk;
    logic             i_rst_n   = 1'b0;
    logic             i_valid   = 1'b0;
    logic [ByteW-1:0] i_in_byte = '0;
    logic             i_ready   = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [CpW-1:0]   o_code_point;
    logic [LenW-1:0]  o_seq_length;
    logic [SkipW-1:0] o_skipped_bytes;
    logic             run_end   = 1'b0;

    int          fail_count;
    int          pending;
    int          chars;
    int unsigned sent = 0;
    bit          idle_on = 1'b1;
    bit          hold_off_req = 1'b0;

    logic [ByteW-1:0] opening [25] = '{
        8'h00, 8'h7f, 8'h80, 8'hff,
        8'hdf, 8'hbf,
        8'he0, 8'h80, 8'hc1, 8'hfe,
        8'hf0, 8'h90, 8'h80, 8'h00,
        8'hfb, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
        8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf
    };

    utf8_stream_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_code_point    (o_code_point),
        .o_seq_length    (o_seq_length),
        .o_skipped_bytes (o_skipped_bytes)
    );

    utf8_stream_decoder_check decode_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_byte       (i_in_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_code_point    (o_code_point),
        .i_seq_length    (o_seq_length),
        .i_skipped_bytes (o_skipped_bytes),
        .i_end           (run_end),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_chars         (chars)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200us;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_byte(input logic [ByteW-1:0] b);
        while (idle_on && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [ByteW-1:0] stray_byte();
        logic [6:0] pick;
        pick = 7'($urandom_range(65));
        return (pick < 64) ? {2'b10, pick[5:0]} : {7'b1111111, pick[0]};
    endfunction

    function automatic logic [ByteW-1:0] cont_byte();
        logic [ByteW-1:0] r;
        r = 8'($urandom);
        return ($urandom_range(15) == 0) ? {7'b1111111, r[0]} : {2'b10, r[5:0]};
    endfunction

    function automatic logic [ByteW-1:0] lead_byte(input int unsigned len);
        logic [ByteW-1:0] r;
        r = 8'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            4:       return {5'b11110, r[2:0]};
            5:       return {6'b111110, r[1:0]};
            default: return {7'b1111110, r[0]};
        endcase
    endfunction

    task automatic send_random();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99);
        if (pick < 75) begin
            len = $urandom_range(1, 6);
            send_byte(lead_byte(len));
            repeat (len - 1) send_byte(cont_byte());
        end else if (pick < 88) begin
            len = $urandom_range(2, 6);
            send_byte(lead_byte(len));
            repeat ($urandom_range(0, len - 2)) send_byte(cont_byte());
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HoldCycles - 1) @(posedge i_clk);
            end else begin
                i_ready <= !(idle_on && $urandom_range(99) < 17);
            end
        end
    end

    initial begin : stimulus
        int unsigned start;
        bit          paused;
        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k]) send_byte(opening[k]);
        drain();

        // Build up the skip count with runs of stray bytes and with a cut-short
        // sequence, and let stray-looking bytes finish a sequence in progress.
        repeat (StrayRun) send_byte(stray_byte());
        send_byte(8'hfc);
        repeat (4) send_byte(8'h80);
        send_byte(8'h41);
        repeat (StrayRun) send_byte(stray_byte());
        send_byte(8'he2);
        send_byte(8'h82);
        repeat (3) send_byte(stray_byte());
        send_byte(8'h42);

        hold_off_req = 1'b1;
        repeat (30) send_byte(lead_byte(1));
        drain();

        start = sent;
        while (sent - start < RandomItems) begin
            idle_on = !(sent - start >= 400 && sent - start < 600);
            if (!paused && sent - start >= 700) begin
                paused = 1'b1;
                drain();
            end
            send_random();
        end
        idle_on = 1'b1;
        drain();
        repeat (TailCycles) @(posedge i_clk);
        run_end <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Sent %0d bytes and checked %0d characters of every length,", sent, chars);
        $display("with skip-count build-up, cut-short sequences and a long output stall.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
